>>> rtl/core/envf_pkg.sv
package envf_pkg;

  // Fixed formats
  localparam int unsigned SAMPLE_W   = 16;  // Q1.15 input sample
  localparam int unsigned ENV_W      = 16;  // unsigned Q1.15 envelope
  localparam int unsigned GATE_W     = 2;
  localparam int unsigned LEVEL_W    = 32;  // filter state
  localparam int unsigned COEFF_W    = 17;  // Q1.16, one is 0x10000
  localparam int unsigned GAIN_W     = 16;  // Q4.12
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned ABS_W      = 20;  // |gained sample|
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned BLOCK_LENGTH = 64;

  // Shared multiplier: signed 33 x 21
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 21;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [COEFF_W-1:0] COEFF_ONE = 17'h10000;

  // Rectifier modes; code 3 behaves as half-wave
  localparam logic [1:0] MODE_HALF   = 2'd0;
  localparam logic [1:0] MODE_FULL   = 2'd1;
  localparam logic [1:0] MODE_SQUARE = 2'd2;

  // Gate codes
  localparam logic [GATE_W-1:0] GATE_OPEN  = 2'd0;
  localparam logic [GATE_W-1:0] GATE_BELOW = 2'd1;
  localparam logic [GATE_W-1:0] GATE_ABOVE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_COEFF    = 3'd1,
    CFG_THRESH   = 3'd2,
    CFG_IN_GAIN  = 3'd3,
    CFG_OUT_GAIN = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_GAIN   = 3'd0,  // sample * input gain
    MUL_SQUARE = 3'd1,  // |v| * |v|
    MUL_RHO    = 3'd2,  // rho * x
    MUL_KEEP   = 3'd3,  // (1 - rho) * level
    MUL_OUT    = 3'd4   // r * output gain
  } mul_sel_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COEFF_W-1:0] rho;      // clamped to one
    logic [COEFF_W-1:0] rho_inv;  // one - rho
    logic [ENV_W-1:0]   thresh;
    logic [GAIN_W-1:0]  in_gain;
    logic [GAIN_W-1:0]  out_gain;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     rect;
    logic     sat;
    logic     acc_load;
    logic     level_load;
    logic     sqrt_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic squared;
    logic sqrt_last;
  } status_t;

endpackage

>>> rtl/core/envf_in_if.sv
interface envf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [envf_pkg::SAMPLE_W-1:0] sample;
  logic                               block_end;

  modport source (output valid, output sample, output block_end, input ready);
  modport sink   (input valid, input sample, input block_end, output ready);
endinterface

>>> rtl/core/envf_out_if.sv
interface envf_out_if;
  logic                          valid;
  logic                          ready;
  logic [envf_pkg::ENV_W-1:0]    envelope;
  logic [envf_pkg::GATE_W-1:0]   gate;

  modport source (output valid, output envelope, output gate, input ready);
  modport sink   (input valid, input envelope, input gate, output ready);
endinterface

>>> rtl/core/envf_cfg.sv
module envf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [envf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [envf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output envf_pkg::cfg_t                  cfg_o
);

  envf_pkg::cfg_t cfg_q, cfg_d;
  logic [envf_pkg::COEFF_W-1:0] rho_wr;

  // anything at or above one acts as one
  assign rho_wr = cfg_data_i[envf_pkg::COEFF_W-1] ? envf_pkg::COEFF_ONE
                                                  : cfg_data_i[envf_pkg::COEFF_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        envf_pkg::CFG_MODE:     cfg_d.mode     = cfg_data_i[1:0];
        envf_pkg::CFG_COEFF: begin
          cfg_d.rho     = rho_wr;
          cfg_d.rho_inv = envf_pkg::COEFF_ONE - rho_wr;
        end
        envf_pkg::CFG_THRESH:   cfg_d.thresh   = cfg_data_i[envf_pkg::ENV_W-1:0];
        envf_pkg::CFG_IN_GAIN:  cfg_d.in_gain  = cfg_data_i[envf_pkg::GAIN_W-1:0];
        envf_pkg::CFG_OUT_GAIN: cfg_d.out_gain = cfg_data_i[envf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= envf_pkg::MODE_HALF;
      cfg_q.rho      <= envf_pkg::COEFF_ONE;
      cfg_q.rho_inv  <= '0;
      cfg_q.thresh   <= 16'h8000;
      cfg_q.in_gain  <= 16'h1000;
      cfg_q.out_gain <= 16'h1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/envf_ctrl.sv
module envf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  envf_pkg::status_t status_i,
  output envf_pkg::cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_GAIN   = 11'b000_0000_0010,
    S_RECT   = 11'b000_0000_0100,
    S_SQ     = 11'b000_0000_1000,
    S_SAT    = 11'b000_0001_0000,
    S_MIX1   = 11'b000_0010_0000,
    S_MIX2   = 11'b000_0100_0000,
    S_LEVEL  = 11'b000_1000_0000,
    S_SQRT   = 11'b001_0000_0000,
    S_OUTMUL = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_sel = envf_pkg::MUL_GAIN;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = envf_pkg::MUL_GAIN;
        state_d       = S_RECT;
      end
      S_RECT: begin
        cmd_o.rect = 1'b1;
        state_d    = status_i.squared ? S_SQ : S_MIX1;
      end
      S_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = envf_pkg::MUL_SQUARE;
        state_d       = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = S_MIX1;
      end
      S_MIX1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = envf_pkg::MUL_RHO;
        state_d       = S_MIX2;
      end
      S_MIX2: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = envf_pkg::MUL_KEEP;
        state_d        = S_LEVEL;
      end
      S_LEVEL: begin
        cmd_o.level_load = 1'b1;
        state_d          = status_i.squared ? S_SQRT : S_OUTMUL;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) begin
          state_d = S_OUTMUL;
        end
      end
      S_OUTMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = envf_pkg::MUL_OUT;
        state_d       = S_FIN;
      end
      S_FIN: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/envf_dp.sv
module envf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  envf_pkg::cfg_t                      cfg_i,
  input  envf_pkg::cmd_t                      cmd_i,
  output envf_pkg::status_t                   status_o,
  input  logic signed [envf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                block_end_i,
  output logic [envf_pkg::ENV_W-1:0]          envelope_o,
  output logic [envf_pkg::GATE_W-1:0]         gate_o
);

  // input holding
  logic signed [envf_pkg::SAMPLE_W-1:0] sample_q;
  logic                                 block_end_q;

  // shared multiplier
  logic signed [envf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [envf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [envf_pkg::PROD_W-1:0]  prod_q;

  // rectifier / filter
  logic signed [20:0]                v;
  logic [20:0]                       neg_v;
  logic [envf_pkg::ABS_W-1:0]        abs_d, abs_q, x_lin;
  logic [envf_pkg::LEVEL_W-1:0]      x_q;
  logic [47:0]                       acc_q;
  logic [47:0]                       lvl_sum;
  logic [envf_pkg::LEVEL_W-1:0]      level_q;

  // square root
  logic [envf_pkg::LEVEL_W-1:0]      rem_q, root_q, root_sel;
  logic [30:0]                       bit_q;
  logic [envf_pkg::LEVEL_W:0]        trial;

  // output / gate
  logic [48:0]                       e_sum;
  logic [36:0]                       e_val;
  logic                              above;
  logic [envf_pkg::CNT_W-1:0]        above_q, samples_q, above_inc, samples_inc;
  logic                              blk_end;
  logic                              squared;

  assign squared = (cfg_i.mode == envf_pkg::MODE_SQUARE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q    <= sample_i;
      block_end_q <= block_end_i;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      envf_pkg::MUL_GAIN: begin
        mul_a = envf_pkg::MUL_A_W'(sample_q);
        mul_b = {5'b0, cfg_i.in_gain};
      end
      envf_pkg::MUL_SQUARE: begin
        mul_a = {13'b0, abs_q};
        mul_b = {1'b0, abs_q};
      end
      envf_pkg::MUL_RHO: begin
        mul_a = {1'b0, x_q};
        mul_b = {4'b0, cfg_i.rho};
      end
      envf_pkg::MUL_KEEP: begin
        mul_a = {1'b0, level_q};
        mul_b = {4'b0, cfg_i.rho_inv};
      end
      envf_pkg::MUL_OUT: begin
        mul_a = {1'b0, root_sel};
        mul_b = {5'b0, cfg_i.out_gain};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // gained sample, floor shift by 12
  assign v     = prod_q[32:12];
  assign neg_v = -v;
  assign abs_d = v[20] ? neg_v[envf_pkg::ABS_W-1:0] : v[envf_pkg::ABS_W-1:0];
  assign x_lin = (cfg_i.mode == envf_pkg::MODE_FULL) ? abs_d
               : (v[20] ? '0 : v[envf_pkg::ABS_W-1:0]);

  // weighted sum never exceeds 2^48 - 1, so no saturation is needed
  assign lvl_sum = acc_q + prod_q[47:0] + 48'd32768;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rect) begin
      abs_q <= abs_d;
      x_q   <= {12'b0, x_lin};
    end else if (cmd_i.sat) begin
      x_q   <= (|prod_q[envf_pkg::PROD_W-1:32]) ? '1 : prod_q[31:0];
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (cmd_i.level_load) begin
      level_q <= lvl_sum[47:16];
    end
  end

  // bit-pair square root, one step per cycle
  assign trial = {1'b0, root_q} + {2'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.level_load) begin
      rem_q  <= lvl_sum[47:16];
      root_q <= '0;
      bit_q  <= 31'(1) << 30;
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q  <= rem_q - trial[envf_pkg::LEVEL_W-1:0];
        root_q <= (root_q >> 1) + {1'b0, bit_q};
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_sel = squared ? root_q : level_q;

  // output gain with rounding, threshold and block vote
  assign e_sum       = prod_q[48:0] + 49'd2048;
  assign e_val       = e_sum[48:12];
  assign above       = e_val > 37'(cfg_i.thresh);
  assign above_inc   = above_q + {6'b0, above};
  assign samples_inc = samples_q + 7'd1;
  assign blk_end     = block_end_q ||
                       (samples_inc >= envf_pkg::CNT_W'(envf_pkg::BLOCK_LENGTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q   <= '0;
      samples_q <= '0;
    end else if (cmd_i.finish) begin
      above_q   <= blk_end ? '0 : above_inc;
      samples_q <= blk_end ? '0 : samples_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      envelope_o <= (|e_val[36:16]) ? '1 : e_val[15:0];
      if (!blk_end) begin
        gate_o <= envf_pkg::GATE_OPEN;
      end else if ({above_inc, 1'b0} > {1'b0, samples_inc}) begin
        gate_o <= envf_pkg::GATE_ABOVE;
      end else begin
        gate_o <= envf_pkg::GATE_BELOW;
      end
    end
  end

  assign status_o.squared   = squared;
  assign status_o.sqrt_last = bit_q[0];

endmodule

>>> rtl/core/rectifier_envelope_follower.sv
// Envelope follower with block majority gate. Each transfer on the input
// channel (a Q1.15 sample plus a block_end flag) produces exactly one transfer
// on the output channel: a saturated unsigned Q1.15 envelope and a gate code
// (0 block still open, 1 majority not above threshold, 2 majority above).
// The sample is scaled by input_gain, rectified (half-wave, full-wave, or
// squared), smoothed by a one-pole filter, square-rooted in squared mode, and
// scaled by output_gain. A block ends on block_end or on its 64th sample.
// One item is processed at a time by a sequencer around a single shared
// 33x21 multiplier; squared mode adds a squaring step and a 16-step square
// root that produces one result bit per cycle.
// A finished result sits in the output register, so the next sample is
// taken while it waits; a stalled output holds back only the final step.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i and must
// only change while no sample is in flight; the filter level is kept across
// mode changes.
module rectifier_envelope_follower (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [envf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [envf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  envf_in_if.sink                         in_i,
  envf_out_if.source                      out_o
);

  envf_pkg::cfg_t    cfg;
  envf_pkg::cmd_t    cmd;
  envf_pkg::status_t status;
  logic              in_ready;
  logic              out_valid;

  // register file
  envf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencer: owns handshakes and step order
  envf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, filter state, block counters, output register
  envf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (in_i.sample),
    .block_end_i (in_i.block_end),
    .envelope_o  (out_o.envelope),
    .gate_o      (out_o.gate)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

`ifndef SYNTH
  // a taken sample keeps the sequencer busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while previous sample still in work");

  // a new result only shows up after the sequencer was working
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> !$past(in_i.ready))
    else $error("result appeared without work");
`endif

endmodule

>>> tb/rectifier_envelope_follower_tb.sv
module rectifier_envelope_follower_tb;
  import envf_pkg::*;

  // Mode code 3 has no name in the package; the block treats it as half-wave.
  localparam logic [1:0] MODE_ALT_HALF = 2'd3;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 53;
  localparam int unsigned HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int unsigned HOLD_AT = 150;      // result count that starts it
  localparam int unsigned DRAIN_CYCLES = 40;  // > squared-mode item latency

  typedef struct packed {
    logic [ENV_W-1:0]  envelope;
    logic [GATE_W-1:0] gate;
  } env_result_t;

  // Tracks the block's configuration and filter/vote state, predicts one
  // result per accepted sample and checks results in order.
  class envelope_scoreboard;
    logic [1:0]         mode;
    logic [COEFF_W-1:0] coeff;
    logic [ENV_W-1:0]   thresh;
    logic [GAIN_W-1:0]  in_gain;
    logic [GAIN_W-1:0]  out_gain;
    logic [LEVEL_W-1:0] level;
    logic [CNT_W-1:0]   above_cnt;
    logic [CNT_W-1:0]   sample_cnt;
    env_result_t        pending_env[$];
    int                 mismatches;
    int                 checked;

    function new();
      mode       = MODE_HALF;
      coeff      = COEFF_ONE;
      thresh     = 16'd32768;
      in_gain    = 16'd4096;
      out_gain   = 16'd4096;
      level      = '0;
      above_cnt  = '0;
      sample_cnt = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:     mode     = data[1:0];
        CFG_COEFF:    coeff    = data[COEFF_W-1:0];
        CFG_THRESH:   thresh   = data[ENV_W-1:0];
        CFG_IN_GAIN:  in_gain  = data[GAIN_W-1:0];
        CFG_OUT_GAIN: out_gain = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Bitwise integer square root, floor.
    function logic [31:0] int_sqrt(logic [31:0] v);
      logic [31:0] rem;
      logic [31:0] root;
      logic [31:0] step;
      rem  = v;
      root = '0;
      step = 32'h4000_0000;
      while (step > rem) step = step >> 2;
      while (step != 0) begin
        if (rem >= root + step) begin
          rem  = rem - (root + step);
          root = (root >> 1) + step;
        end else begin
          root = root >> 1;
        end
        step = step >> 2;
      end
      return root;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      longint      gained;
      longint      mag;
      longint      x;
      longint      rho;
      longint      nxt;
      longint      r;
      longint      e;
      env_result_t res;
      // Q1.15 * Q4.12 -> Q.15, floor
      gained = (longint'(s) * longint'(in_gain)) >>> 12;
      mag    = (gained < 0) ? -gained : gained;
      case (mode)
        MODE_FULL:   x = mag;
        MODE_SQUARE: begin
          x = mag * mag;
          if (x > longint'(32'hFFFF_FFFF)) x = longint'(32'hFFFF_FFFF);
        end
        default:     x = (gained > 0) ? gained : 0;
      endcase
      rho = (coeff > COEFF_ONE) ? longint'(COEFF_ONE) : longint'(coeff);
      nxt = (rho * x + (65536 - rho) * longint'(level) + 32768) >>> 16;
      if (nxt > longint'(32'hFFFF_FFFF)) nxt = longint'(32'hFFFF_FFFF);
      level = nxt[31:0];
      r = (mode == MODE_SQUARE) ? longint'(int_sqrt(level)) : longint'(level);
      e = (r * longint'(out_gain) + 2048) >>> 12;

      res.gate = GATE_OPEN;
      if (e > longint'(thresh)) above_cnt = above_cnt + 1'b1;
      sample_cnt = sample_cnt + 1'b1;
      if (last || sample_cnt >= BLOCK_LENGTH) begin
        // strict majority; a tie is reported as below
        res.gate   = (2 * int'(above_cnt) > int'(sample_cnt)) ? GATE_ABOVE : GATE_BELOW;
        above_cnt  = '0;
        sample_cnt = '0;
      end
      res.envelope = (e > 65535) ? 16'hFFFF : e[ENV_W-1:0];
      pending_env.push_back(res);
    endfunction

    function void check_result(logic [ENV_W-1:0] envelope, logic [GATE_W-1:0] gate);
      env_result_t want;
      checked++;
      if (pending_env.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with no sample outstanding: envelope %0d gate %0d",
                   checked, envelope, gate);
        return;
      end
      want = pending_env.pop_front();
      if (envelope !== want.envelope || gate !== want.gate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: envelope exp %0d got %0d, gate exp %0d got %0d",
                   checked, want.envelope, envelope, want.gate, gate);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  bit                    steady;  // no idling on either side while set

  envf_in_if  in_if ();
  envf_out_if out_if ();

  envelope_scoreboard env_sb;

  rectifier_envelope_follower u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // One register write per cycle; cfg_we_i stays high across back-to-back
  // writes and is lowered by the caller after the last one.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    env_sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Drop the sample valid, wait until every outstanding result has been
  // transferred (block idle), then load a full register set.
  task automatic apply_config(input logic [1:0] mode, input logic [COEFF_W-1:0] coeff,
                              input logic [ENV_W-1:0] thresh,
                              input logic [GAIN_W-1:0] in_gain,
                              input logic [GAIN_W-1:0] out_gain);
    in_if.valid <= 1'b0;
    while (env_sb.pending_env.size() != 0) @(negedge clk_i);
    write_reg(CFG_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_COEFF, coeff);
    write_reg(CFG_THRESH, CFG_DATA_W'(thresh));
    write_reg(CFG_IN_GAIN, CFG_DATA_W'(in_gain));
    write_reg(CFG_OUT_GAIN, CFG_DATA_W'(out_gain));
    cfg_we_i <= 1'b0;
  endtask

  // Called at a falling edge. Random gaps first, then offer the sample and
  // hold it until the transfer; returns at the next falling edge with valid
  // still high so a following item can go out without a bubble.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    while (!steady && $urandom_range(99) < 32) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample    <= s;
    in_if.block_end <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    env_sb.note_sample(s, last);
    @(negedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return SAMPLE_W'(int'($urandom_range(127)) - 64);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(6))
      0:       return '0;
      1:       return 17'd1;
      2:       return COEFF_ONE;
      3:       return 17'h1FFFF;                         // above one, clamps
      4:       return COEFF_W'($urandom_range(17'h1FFFF, 17'h10001));
      default: return COEFF_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'd4096;
      default: return GAIN_W'($urandom_range(16384));
    endcase
  endfunction

  function automatic logic [ENV_W-1:0] pick_thresh();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return ENV_W'($urandom_range(2048));
      default: return ENV_W'($urandom);
    endcase
  endfunction

  // Result side: ready changes on the falling edge, transfers are taken on
  // the rising edge. One long hold-off lets the block back up into its input.
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && env_sb.checked == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (steady) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 32);
      end
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready)
        env_sb.check_result(out_if.envelope, out_if.gate);
    end
  end

  // Main sequence: reset, directed items, then random phases, each phase
  // under its own register set.
  initial begin : stimulus
    int unsigned end_odds [NUM_PHASES];
    logic [1:0]  mode;
    logic        last;
    env_sb = new();
    end_odds = '{3, 0, 12, 2, 40, 0, 6, 20, 1, 8};  // 0: never, blocks overflow
    steady          = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    in_if.valid     <= 1'b0;
    in_if.sample    <= '0;
    in_if.block_end <= 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Unity gains, threshold at 0.5: envelope equals sample.
    apply_config(MODE_HALF, COEFF_ONE, 16'd16384, 16'd4096, 16'd4096);
    send_sample(16'sd16384, 1'b0);   // equal to threshold, does not count
    send_sample(16'sd16385, 1'b1);   // one of two above: tie, below
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sd20000, 1'b1);   // two of two above
    send_sample(16'sh8000, 1'b0);    // negative rectifies to zero
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);

    // Full-wave, coefficient above one, maximum gains: envelope saturates.
    apply_config(MODE_FULL, 17'h1FFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd0, 1'b1);

    // Squared mode: level read as Q.30 after the mode change; square saturates.
    apply_config(MODE_SQUARE, 17'd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sd100, 1'b1);

    // Mode code 3 with rho zero: level frozen, reinterpreted as Q.15.
    apply_config(MODE_ALT_HALF, '0, 16'd32768, 16'd0, 16'd4096);
    send_sample(16'sd12345, 1'b0);
    send_sample(-16'sd5, 1'b1);

    // Smallest nonzero rho, output gain zero.
    apply_config(MODE_FULL, 17'd1, 16'd0, 16'd4096, 16'd0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = (p < 4) ? 2'(p) : 2'($urandom_range(3));
      apply_config(mode, pick_coeff(), pick_thresh(), pick_gain(), pick_gain());
      steady = (p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        last = (end_odds[p] != 0) && ($urandom_range(end_odds[p] - 1) == 0);
        send_sample(pick_sample(), last);
      end
    end
    steady = 1'b0;

    in_if.valid <= 1'b0;
    while (env_sb.pending_env.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (env_sb.mismatches == 0 && env_sb.pending_env.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
